/* rtl/prbs_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prbs_pkg
// Shared types and constants of the packet ring buffer with seek.
// ----------------------------------------------------------------------------
package prbs_pkg;

  localparam int RING_DEPTH = 64;
  localparam int IDX_W      = $clog2(RING_DEPTH);
  localparam int MAX_LEN    = 16384;
  localparam int BOUND_MUL  = RING_DEPTH * 2;

  localparam logic [31:0] STALE_WINDOW = 32'hfff0_0000;
  localparam logic [2:0]  KIND_HEAD    = 3'd1;
  localparam logic [2:0]  KIND_DATA    = 3'd2;

  localparam logic [1:0] REQ_WRITE = 2'd0;
  localparam logic [1:0] REQ_READ  = 2'd1;
  localparam logic [1:0] REQ_PRI   = 2'd2;
  localparam logic [1:0] REQ_SEEK  = 2'd3;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_BAD_LEN   = 3'd1;
  localparam logic [2:0] ST_STALE     = 3'd2;
  localparam logic [2:0] ST_FULL      = 3'd3;
  localparam logic [2:0] ST_EMPTY     = 3'd4;
  localparam logic [2:0] ST_BEHIND    = 3'd5;
  localparam logic [2:0] ST_NOT_FOUND = 3'd6;

  typedef struct packed {
    logic [2:0]  ptype;
    logic [14:0] len;
    logic [31:0] pos;
    logic        cont;
    logic [7:0]  prio;
    logic [31:0] seq;
  } slot_t;

  localparam int SLOT_W = $bits(slot_t);

  typedef enum logic [2:0] {
    TAG_NONE, TAG_LEN0, TAG_LAST, TAG_PRI, TAG_FDAT, TAG_MATCH, TAG_OLD, TAG_LATE
  } tag_t;

  typedef enum logic [1:0] {
    SRC_ZERO, SRC_LAST, SRC_CNT, SRC_FIRST
  } rd_src_t;

  typedef enum logic [3:0] {
    OP_NONE, OP_LATCH, OP_WDEC, OP_RDEC, OP_STEP, OP_PFIN, OP_FINIT, OP_SPOS, OP_MFIN
  } op_t;

  typedef struct packed {
    op_t     op;
    logic    rd_en;
    rd_src_t rd_src;
    tag_t    tag;
  } cmd_t;

  typedef struct packed {
    logic       wc_zero;
    logic       rd_err;
    logic       scan_last;
    logic [1:0] req;
  } stat_t;

endpackage

/* rtl/prbs_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prbs_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module prbs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* rtl/prbs_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prbs_ctrl
// Request sequencer: issues descriptor reads, scans and decisions.
// ----------------------------------------------------------------------------
module prbs_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  logic [1:0]      req_type,
  input  prbs_pkg::stat_t stat,
  output prbs_pkg::cmd_t  cmd,
  output logic            busy,
  output logic            done
);
  import prbs_pkg::*;

  typedef enum logic [18:0] {
    S_IDLE  = 19'b000_0000_0000_0000_0001,
    S_K0    = 19'b000_0000_0000_0000_0010,
    S_LAST  = 19'b000_0000_0000_0000_0100,
    S_LWAIT = 19'b000_0000_0000_0000_1000,
    S_WDEC  = 19'b000_0000_0000_0001_0000,
    S_RDEC  = 19'b000_0000_0000_0010_0000,
    S_PSCAN = 19'b000_0000_0000_0100_0000,
    S_PWAIT = 19'b000_0000_0000_1000_0000,
    S_PFIN  = 19'b000_0000_0001_0000_0000,
    S_FSCAN = 19'b000_0000_0010_0000_0000,
    S_FWAIT = 19'b000_0000_0100_0000_0000,
    S_SPOS  = 19'b000_0000_1000_0000_0000,
    S_MSCAN = 19'b000_0001_0000_0000_0000,
    S_MWAIT = 19'b000_0010_0000_0000_0000,
    S_MFIN  = 19'b000_0100_0000_0000_0000,
    S_TOLD  = 19'b000_1000_0000_0000_0000,
    S_TLATE = 19'b001_0000_0000_0000_0000,
    S_TWAIT = 19'b010_0000_0000_0000_0000,
    S_DONE  = 19'b100_0000_0000_0000_0000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '{op: OP_NONE, rd_en: 1'b0, rd_src: SRC_ZERO, tag: TAG_NONE};
    case (state)
      S_IDLE: begin
        if (start) begin
          cmd.op = OP_LATCH;
          case (req_type)
            REQ_WRITE: state_next = stat.wc_zero ? S_WDEC : S_LAST;
            REQ_SEEK:  state_next = stat.wc_zero ? S_TOLD : S_K0;
            default:   state_next = S_RDEC;
          endcase
        end
      end
      S_K0: begin
        cmd = '{op: OP_NONE, rd_en: 1'b1, rd_src: SRC_ZERO, tag: TAG_LEN0};
        state_next = S_LAST;
      end
      S_LAST: begin
        cmd = '{op: OP_NONE, rd_en: 1'b1, rd_src: SRC_LAST, tag: TAG_LAST};
        state_next = S_LWAIT;
      end
      S_LWAIT: begin
        cmd.op = OP_FINIT;
        state_next = (stat.req == REQ_WRITE) ? S_WDEC : S_FSCAN;
      end
      S_WDEC: begin
        cmd.op = OP_WDEC;
        state_next = S_TOLD;
      end
      S_RDEC: begin
        cmd.op = OP_RDEC;
        state_next = stat.rd_err ? S_TOLD : S_PSCAN;
      end
      S_PSCAN: begin
        cmd = '{op: OP_STEP, rd_en: 1'b1, rd_src: SRC_CNT, tag: TAG_PRI};
        if (stat.scan_last) state_next = S_PWAIT;
      end
      S_PWAIT: state_next = S_PFIN;
      S_PFIN: begin
        cmd.op = OP_PFIN;
        state_next = S_TOLD;
      end
      S_FSCAN: begin
        cmd = '{op: OP_STEP, rd_en: 1'b1, rd_src: SRC_CNT, tag: TAG_FDAT};
        if (stat.scan_last) state_next = S_FWAIT;
      end
      S_FWAIT: state_next = S_SPOS;
      S_SPOS: begin
        cmd.op = OP_SPOS;
        state_next = S_MSCAN;
      end
      S_MSCAN: begin
        cmd = '{op: OP_STEP, rd_en: 1'b1, rd_src: SRC_CNT, tag: TAG_MATCH};
        if (stat.scan_last) state_next = S_MWAIT;
      end
      S_MWAIT: state_next = S_MFIN;
      S_MFIN: begin
        cmd.op = OP_MFIN;
        state_next = S_TOLD;
      end
      S_TOLD: begin
        if (stat.wc_zero) begin
          state_next = S_DONE;
        end else begin
          cmd = '{op: OP_NONE, rd_en: 1'b1, rd_src: SRC_FIRST, tag: TAG_OLD};
          state_next = S_TLATE;
        end
      end
      S_TLATE: begin
        cmd = '{op: OP_NONE, rd_en: 1'b1, rd_src: SRC_LAST, tag: TAG_LATE};
        state_next = S_TWAIT;
      end
      S_TWAIT: state_next = S_DONE;
      S_DONE:  state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  assign busy = (state != S_IDLE);
  assign done = (state == S_DONE);

  a_start_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy) else $error("accepted item did not raise busy");
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |=> !busy && !done) else $error("result strobe not followed by idle");
  a_scan_src: assert property (@(posedge clk) disable iff (rst)
    cmd.op == OP_STEP |-> cmd.rd_en && cmd.rd_src == SRC_CNT)
    else $error("scan step without counter read");

endmodule

/* rtl/prbs_dp.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prbs_dp
// Counts, descriptor ring memory, scan registers and result registers.
// ----------------------------------------------------------------------------
module prbs_dp (
  input  logic            clk,
  input  logic            rst,
  input  prbs_pkg::cmd_t  cmd,
  output prbs_pkg::stat_t stat,
  input  logic            keep_downstreams,
  input  logic [1:0]      req_type,
  input  logic            update_read,
  input  logic [2:0]      in_type,
  input  logic [14:0]     in_len,
  input  logic [31:0]     in_pos,
  input  logic            in_cont,
  input  logic [7:0]      in_priority,
  input  logic [31:0]     seek_pos,
  output logic [2:0]      status,
  output logic [2:0]      out_type,
  output logic [14:0]     out_len,
  output logic [31:0]     out_pos,
  output logic            out_cont,
  output logic [7:0]      out_priority,
  output logic [31:0]     out_seq,
  output logic [31:0]     oldest_pos,
  output logic [31:0]     latest_pos
);
  import prbs_pkg::*;

  logic [31:0] wc, rc, cnt, scan_end;
  logic [1:0]  req;
  logic        upd;
  slot_t       wr_slot_in, rs, best, rdata, wdata;
  logic [31:0] spos_in, spos, fpos, lpos, bound;
  logic [14:0] llen;
  logic [2:0]  ltype;
  logic        ffound, found;
  logic [IDX_W-1:0] best_idx, addr_q, raddr, waddr;
  logic        first_q, we;
  tag_t        tag_q;
  logic [31:0] first, last, epos, lbound, dl;
  logic        stale, full, len_bad, spos_fix, pri_first;

  assign first = (wc >= 32'(RING_DEPTH)) ? wc - 32'(RING_DEPTH) : 32'd0;
  assign last  = wc - 32'd1;

  always_comb begin
    case (cmd.rd_src)
      SRC_ZERO:  raddr = '0;
      SRC_LAST:  raddr = last[IDX_W-1:0];
      SRC_CNT:   raddr = cnt[IDX_W-1:0];
      SRC_FIRST: raddr = first[IDX_W-1:0];
      default:   raddr = '0;
    endcase
  end

  assign pri_first = (cnt == rc);

  assign len_bad = (wr_slot_in.len == 15'd0) || (wr_slot_in.len > 15'(MAX_LEN));
  assign dl      = wr_slot_in.pos - lpos;
  assign stale   = keep_downstreams && (wc != 32'd0) && (ltype != KIND_HEAD) &&
                   (lpos != 32'd0) && ((dl == 32'd0) || (dl > STALE_WINDOW));
  assign full    = (wc - rc) >= 32'(RING_DEPTH);

  assign epos     = lpos + 32'(llen);
  assign lbound   = lpos + bound;
  assign spos_fix = (spos_in < fpos && fpos <= lpos && spos_in != epos) ||
                    (spos_in < fpos && lpos < fpos && spos_in > lbound) ||
                    (spos_in > lpos && lpos >= fpos && (spos_in - lpos) > bound);

  always_comb begin
    we    = 1'b0;
    waddr = wc[IDX_W-1:0];
    wdata = wr_slot_in;
    wdata.seq = wc;
    if (cmd.op == OP_WDEC) begin
      we = !len_bad && !stale && !full;
    end else if (cmd.op == OP_PFIN) begin
      we    = (best_idx != rc[IDX_W-1:0]);
      waddr = best_idx;
      wdata = rs;
    end
  end

  prbs_ram #(.WIDTH(SLOT_W), .DEPTH(RING_DEPTH)) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (cmd.rd_en),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      wc    <= '0;
      rc    <= '0;
      tag_q <= TAG_NONE;
    end else begin
      tag_q <= cmd.rd_en ? cmd.tag : TAG_NONE;
      if (cmd.op == OP_WDEC && we) begin
        wc <= wc + 32'd1;
        if (upd) rc <= wc + 32'd1;
      end
      if (cmd.op == OP_PFIN) rc <= rc + 32'd1;
    end
  end

  always_ff @(posedge clk) begin
    addr_q  <= raddr;
    first_q <= pri_first;
    case (cmd.op)
      OP_LATCH: begin
        req          <= req_type;
        upd          <= update_read;
        wr_slot_in   <= '{ptype: in_type, len: in_len, pos: in_pos, cont: in_cont,
                          prio: in_priority, seq: 32'd0};
        spos_in      <= seek_pos;
        status       <= (req_type == REQ_SEEK && wc == 32'd0) ? ST_NOT_FOUND : ST_OK;
        out_type     <= '0;
        out_len      <= '0;
        out_pos      <= '0;
        out_cont     <= 1'b0;
        out_priority <= '0;
        out_seq      <= '0;
        oldest_pos   <= '0;
        latest_pos   <= '0;
        ffound       <= 1'b0;
        found        <= 1'b0;
        fpos         <= '0;
      end
      OP_WDEC: begin
        if (len_bad)    status <= ST_BAD_LEN;
        else if (stale) status <= ST_STALE;
        else if (full)  status <= ST_FULL;
      end
      OP_RDEC: begin
        if (rc < first)    status <= ST_BEHIND;
        else if (rc >= wc) status <= ST_EMPTY;
        cnt      <= rc;
        scan_end <= (req == REQ_PRI) ? wc : rc + 32'd1;
      end
      OP_STEP:  cnt <= cnt + 32'd1;
      OP_FINIT: begin
        cnt      <= first;
        scan_end <= wc;
      end
      OP_SPOS: begin
        spos <= spos_fix ? fpos : spos_in;
        cnt  <= first;
      end
      OP_PFIN: begin
        out_type     <= best.ptype;
        out_len      <= best.len;
        out_pos      <= best.pos;
        out_cont     <= best.cont;
        out_priority <= best.prio;
        out_seq      <= best.seq;
      end
      OP_MFIN: begin
        if (!found) status <= ST_NOT_FOUND;
      end
      default: ;
    endcase

    case (tag_q)
      TAG_LEN0: bound <= 32'(rdata.len) * 32'(BOUND_MUL);
      TAG_LAST: begin
        lpos  <= rdata.pos;
        llen  <= rdata.len;
        ltype <= rdata.ptype;
      end
      TAG_PRI: begin
        if (first_q) begin
          rs       <= rdata;
          best     <= rdata;
          best_idx <= addr_q;
        end else if (rdata.prio > best.prio) begin
          best     <= rdata;
          best_idx <= addr_q;
        end
      end
      TAG_FDAT: begin
        if (!ffound && rdata.ptype == KIND_DATA) begin
          fpos   <= rdata.pos;
          ffound <= 1'b1;
        end
      end
      TAG_MATCH: begin
        if (!found && rdata.pos >= spos && (rdata.pos - spos) <= bound) begin
          found        <= 1'b1;
          out_type     <= rdata.ptype;
          out_len      <= rdata.len;
          out_pos      <= rdata.pos;
          out_cont     <= rdata.cont;
          out_priority <= rdata.prio;
          out_seq      <= rdata.seq;
        end
      end
      TAG_OLD:  oldest_pos <= rdata.pos;
      TAG_LATE: latest_pos <= rdata.pos;
      default: ;
    endcase
  end

  assign stat = '{wc_zero: (wc == 32'd0), rd_err: (rc < first) || (rc >= wc),
                  scan_last: (cnt + 32'd1 == scan_end), req: req};

  a_no_wr_in_flight: assert property (@(posedge clk) disable iff (rst)
    we |-> tag_q == TAG_NONE) else $error("ring write while read data in flight");
  a_fill: assert property (@(posedge clk) disable iff (rst)
    (wc - rc) <= 32'(RING_DEPTH)) else $error("read count fell behind ring");
  a_wc_step: assert property (@(posedge clk) disable iff (rst)
    wc != $past(wc) |-> wc == $past(wc) + 32'd1) else $error("write count jumped");

endmodule

/* rtl/packet_ring_buffer_seek.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// packet_ring_buffer_seek
// Ring of packet descriptors with write, read, priority read and seek.
// ----------------------------------------------------------------------------
// channel   handshake                          payload
// request   start, busy (taken at start&!busy) req_type .. seek_pos
// result    done (one-cycle strobe)            status .. latest_pos
// config    apb psel/penable/pwrite, pready=1  keep_downstreams at 0x0
//
// a write into an empty ring skips the last-descriptor read; either read
// skips its scan on an error; a priority read scans the unread descriptors,
// a seek scans the held ones twice (none on an empty ring); scans read one
// descriptor a cycle through the single ring memory read port.
// rst is synchronous; the ring memory holds no reset state.
// busy stays high through the done cycle; the receiver cannot stall.
// ----------------------------------------------------------------------------
module packet_ring_buffer_seek (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  req_type,
  input  logic        update_read,
  input  logic [2:0]  in_type,
  input  logic [14:0] in_len,
  input  logic [31:0] in_pos,
  input  logic        in_cont,
  input  logic [7:0]  in_priority,
  input  logic [31:0] seek_pos,
  output logic        done,
  output logic [2:0]  status,
  output logic [2:0]  out_type,
  output logic [14:0] out_len,
  output logic [31:0] out_pos,
  output logic        out_cont,
  output logic [7:0]  out_priority,
  output logic [31:0] out_seq,
  output logic [31:0] oldest_pos,
  output logic [31:0] latest_pos,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import prbs_pkg::*;

  logic  keep_downstreams;
  cmd_t  cmd;
  stat_t stat;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      keep_downstreams <= 1'b0;
    end else if (psel && penable && pwrite && !paddr[2]) begin
      keep_downstreams <= pwdata[0];
    end
  end

  assign prdata = (paddr[2] == 1'b0) ? {31'd0, keep_downstreams} : 32'd0;

  prbs_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .req_type (req_type),
    .stat     (stat),
    .cmd      (cmd),
    .busy     (busy),
    .done     (done)
  );

  prbs_dp u_dp (
    .clk              (clk),
    .rst              (rst),
    .cmd              (cmd),
    .stat             (stat),
    .keep_downstreams (keep_downstreams),
    .req_type         (req_type),
    .update_read      (update_read),
    .in_type          (in_type),
    .in_len           (in_len),
    .in_pos           (in_pos),
    .in_cont          (in_cont),
    .in_priority      (in_priority),
    .seek_pos         (seek_pos),
    .status           (status),
    .out_type         (out_type),
    .out_len          (out_len),
    .out_pos          (out_pos),
    .out_cont         (out_cont),
    .out_priority     (out_priority),
    .out_seq          (out_seq),
    .oldest_pos       (oldest_pos),
    .latest_pos       (latest_pos)
  );

endmodule

/* verif/packet_ring_buffer_seek_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// packet_ring_buffer_seek_tb
// Self-checking bench for the packet descriptor ring with read, priority read
// and seek. A queue of pending items feeds a clocked driver; a clocked
// monitor checks every result strobe against a descriptor-ring predictor.
// Phases vary the idle rate of the sender and the stale-position check.
// ----------------------------------------------------------------------------
module packet_ring_buffer_seek_tb;
  import prbs_pkg::*;

  typedef struct packed {
    logic [1:0]  req;
    logic        upd;
    logic [2:0]  ptype;
    logic [14:0] len;
    logic [31:0] pos;
    logic        cont;
    logic [7:0]  prio;
    logic [31:0] spos;
  } req_item_t;

  typedef struct packed {
    logic [2:0]  st;
    logic [2:0]  ptype;
    logic [14:0] len;
    logic [31:0] pos;
    logic        cont;
    logic [7:0]  prio;
    logic [31:0] seq;
    logic [31:0] oldest;
    logic [31:0] latest;
  } ring_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  logic [1:0]  req_type = REQ_WRITE;
  logic        update_read = 1'b0;
  logic [2:0]  in_type = '0;
  logic [14:0] in_len = '0;
  logic [31:0] in_pos = '0;
  logic        in_cont = 1'b0;
  logic [7:0]  in_priority = '0;
  logic [31:0] seek_pos = '0;
  logic        done;
  logic [2:0]  status;
  logic [2:0]  out_type;
  logic [14:0] out_len;
  logic [31:0] out_pos;
  logic        out_cont;
  logic [7:0]  out_priority;
  logic [31:0] out_seq;
  logic [31:0] oldest_pos;
  logic [31:0] latest_pos;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  packet_ring_buffer_seek i_dut (.*);

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // predictor state
  logic        keep_down;
  logic [31:0] wr_count;
  logic [31:0] rd_count;
  slot_t       ring [RING_DEPTH];

  req_item_t    pending_items[$];
  ring_result_t expected_results[$];
  int idle_pct = 0;
  int mismatches = 0;
  int checked = 0;
  int ok_writes = 0, ok_reads = 0, ok_seeks = 0, full_hits = 0, stale_hits = 0;

  function automatic logic [31:0] first_held();
    return (wr_count >= RING_DEPTH) ? wr_count - RING_DEPTH : 32'd0;
  endfunction

  function automatic ring_result_t ring_predict(req_item_t it);
    ring_result_t r;
    logic [31:0] last_pos, d, fpos, lpos, epos, bound, spos, sum, diff, k, n, first;
    int best, rs, s;
    logic found;
    r = '0;
    case (it.req)
      REQ_WRITE: begin
        if (it.len == 0 || it.len > MAX_LEN) begin
          r.st = ST_BAD_LEN;
        end else begin
          r.st = ST_OK;
          if (keep_down && wr_count != 0) begin
            s = (wr_count - 1) % RING_DEPTH;
            last_pos = ring[s].pos;
            d = it.pos - last_pos;
            if (ring[s].ptype == KIND_HEAD) last_pos = 0;
            if (last_pos != 0 && (d == 0 || d > STALE_WINDOW)) r.st = ST_STALE;
          end
          if (r.st == ST_OK && wr_count - rd_count >= RING_DEPTH) r.st = ST_FULL;
          if (r.st == ST_OK) begin
            s = wr_count % RING_DEPTH;
            ring[s] = '{ptype: it.ptype, len: it.len, pos: it.pos, cont: it.cont,
                        prio: it.prio, seq: wr_count};
            wr_count = wr_count + 1;
            if (it.upd) rd_count = wr_count;
          end
        end
      end
      REQ_READ, REQ_PRI: begin
        if (rd_count < first_held()) begin
          r.st = ST_BEHIND;
        end else if (rd_count >= wr_count) begin
          r.st = ST_EMPTY;
        end else begin
          r.st = ST_OK;
          rs = rd_count % RING_DEPTH;
          best = rs;
          if (it.req == REQ_PRI)
            for (k = rd_count + 1; k < wr_count; k++)
              if (ring[k % RING_DEPTH].prio > ring[best].prio) best = k % RING_DEPTH;
          {r.ptype, r.len, r.pos, r.cont, r.prio, r.seq} = ring[best];
          if (best != rs) ring[best] = ring[rs];
          rd_count = rd_count + 1;
        end
      end
      default: begin
        r.st = ST_NOT_FOUND;
        if (wr_count != 0) begin
          bound = ring[0].len * BOUND_MUL;
          first = first_held();
          n = wr_count - first;
          fpos = 0;
          for (k = 0; k < n; k++)
            if (ring[(first + k) % RING_DEPTH].ptype == KIND_DATA) begin
              fpos = ring[(first + k) % RING_DEPTH].pos;
              break;
            end
          s = (wr_count - 1) % RING_DEPTH;
          lpos = ring[s].pos;
          epos = lpos + ring[s].len;
          spos = it.spos;
          sum = lpos + bound;
          diff = spos - lpos;
          if ((spos < fpos && fpos <= lpos && spos != epos) ||
              (spos < fpos && lpos < fpos && spos > sum) ||
              (spos > lpos && lpos >= fpos && diff > bound))
            spos = fpos;
          found = 1'b0;
          for (k = 0; k < n && !found; k++) begin
            s = (first + k) % RING_DEPTH;
            diff = ring[s].pos - spos;
            if (ring[s].pos >= spos && diff <= bound) begin
              found = 1'b1;
              r.st = ST_OK;
              {r.ptype, r.len, r.pos, r.cont, r.prio, r.seq} = ring[s];
            end
          end
        end
      end
    endcase
    if (wr_count != 0) begin
      r.oldest = ring[first_held() % RING_DEPTH].pos;
      r.latest = ring[(wr_count - 1) % RING_DEPTH].pos;
    end
    return r;
  endfunction

  function automatic void tally(req_item_t it, ring_result_t r);
    if (r.st == ST_FULL) full_hits++;
    if (r.st == ST_STALE) stale_hits++;
    if (r.st == ST_OK) begin
      if (it.req == REQ_WRITE) ok_writes++;
      else if (it.req == REQ_SEEK) ok_seeks++;
      else ok_reads++;
    end
  endfunction

  task automatic present(req_item_t it);
    start <= 1'b1;
    req_type <= it.req;
    update_read <= it.upd;
    in_type <= it.ptype;
    in_len <= it.len;
    in_pos <= it.pos;
    in_cont <= it.cont;
    in_priority <= it.prio;
    seek_pos <= it.spos;
  endtask

  // driver
  always @(posedge clk) begin
    req_item_t it;
    ring_result_t r;
    if (rst) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        it = pending_items.pop_front();
        r = ring_predict(it);
        tally(it, r);
        expected_results.push_back(r);
      end
      if (!(start && busy)) begin
        if (pending_items.size() > 0 && $urandom_range(99) >= idle_pct)
          present(pending_items[0]);
        else
          start <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    ring_result_t got, exp_r;
    if (!rst && done) begin
      got = '{st: status, ptype: out_type, len: out_len, pos: out_pos, cont: out_cont,
              prio: out_priority, seq: out_seq, oldest: oldest_pos, latest: latest_pos};
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result: %p", got);
      end else begin
        exp_r = expected_results.pop_front();
        checked++;
        if (got !== exp_r) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch at %0t\n  exp %p\n  got %p", $realtime, exp_r, got);
        end
      end
    end
  end

  task automatic reg_write(logic v);
    @(posedge clk);
    psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0; paddr <= '0; pwdata <= {31'd0, v};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    keep_down = v;
  endtask

  task automatic wait_drained();
    while (pending_items.size() > 0 || expected_results.size() > 0 || busy)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  function automatic req_item_t mk(logic [1:0] rq, logic u, logic [2:0] ty,
                                   logic [14:0] ln, logic [31:0] p, logic c,
                                   logic [7:0] pr, logic [31:0] sp);
    req_item_t it;
    it = '{req: rq, upd: u, ptype: ty, len: ln, pos: p, cont: c, prio: pr, spos: sp};
    return it;
  endfunction

  logic [31:0] stream_pos;

  function automatic req_item_t random_item();
    req_item_t it;
    int pick;
    it = mk(2'($urandom_range(3)), $urandom_range(99) < 8, $urandom_range(99) < 70 ? 3'd2 :
            3'($urandom_range(7)), 15'($urandom_range(1, 1500)), stream_pos,
            1'($urandom_range(1)), 8'($urandom), stream_pos - $urandom_range(20000));
    pick = $urandom_range(99);
    if (pick < 45) it.req = REQ_WRITE;
    else if (pick < 65) it.req = REQ_READ;
    else if (pick < 80) it.req = REQ_PRI;
    else it.req = REQ_SEEK;
    if ($urandom_range(99) < 5) it.len = 15'($urandom);
    if ($urandom_range(99) < 3) it.len = 0;
    if ($urandom_range(99) < 3) it.len = 15'(MAX_LEN);
    if ($urandom_range(99) < 6) it.pos = $urandom;
    if ($urandom_range(99) < 25) it.spos = $urandom;
    else if ($urandom_range(99) < 30) it.spos = stream_pos + $urandom_range(3000);
    if (it.req == REQ_WRITE && $urandom_range(99) < 95) stream_pos = stream_pos + it.len;
    return it;
  endfunction

  initial begin
    int phase_idle[4];
    logic phase_keep[4];
    phase_idle = '{0, 84, 0, 6};
    phase_keep = '{1'b0, 1'b1, 1'b1, 1'b0};
    keep_down = 1'b0;
    wr_count = '0;
    rd_count = '0;
    foreach (ring[i]) ring[i] = '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // directed: empty ring, bad lengths, extremes, each request kind
    pending_items.push_back(mk(REQ_SEEK, 0, 2, 0, 0, 0, 0, 32'h1234));
    pending_items.push_back(mk(REQ_READ, 0, 2, 0, 0, 0, 0, 0));
    pending_items.push_back(mk(REQ_PRI, 0, 2, 0, 0, 0, 0, 0));
    pending_items.push_back(mk(REQ_WRITE, 0, 2, 0, 32'h100, 0, 1, 0));
    pending_items.push_back(mk(REQ_WRITE, 0, 2, 15'(MAX_LEN + 1), 32'h100, 0, 1, 0));
    pending_items.push_back(mk(REQ_WRITE, 0, 2, 15'h7fff, 32'h100, 0, 1, 0));
    pending_items.push_back(mk(REQ_WRITE, 0, 1, 100, 32'h0, 0, 3, 0));
    pending_items.push_back(mk(REQ_WRITE, 0, 2, 15'(MAX_LEN), 32'h64, 1, 8'hff, 0));
    pending_items.push_back(mk(REQ_WRITE, 0, 7, 1, 32'hffff_ffff, 1, 0, 0));
    pending_items.push_back(mk(REQ_WRITE, 0, 5, 20, 32'h4064, 0, 8'h80, 0));
    pending_items.push_back(mk(REQ_WRITE, 0, 4, 30, 32'h4078, 1, 8'h80, 0));
    pending_items.push_back(mk(REQ_WRITE, 0, 3, 40, 32'h4096, 0, 8'h7f, 0));
    pending_items.push_back(mk(REQ_SEEK, 0, 0, 0, 0, 0, 0, 32'h0));
    pending_items.push_back(mk(REQ_SEEK, 0, 0, 0, 0, 0, 0, 32'h4070));
    pending_items.push_back(mk(REQ_SEEK, 0, 0, 0, 0, 0, 0, 32'hffff_ffff));
    pending_items.push_back(mk(REQ_SEEK, 0, 0, 0, 0, 0, 0, 32'h40be));
    pending_items.push_back(mk(REQ_PRI, 0, 0, 0, 0, 0, 0, 0));
    pending_items.push_back(mk(REQ_READ, 0, 0, 0, 0, 0, 0, 0));
    pending_items.push_back(mk(REQ_PRI, 0, 0, 0, 0, 0, 0, 0));
    pending_items.push_back(mk(REQ_WRITE, 1, 6, 5, 32'h5000, 0, 9, 0));
    pending_items.push_back(mk(REQ_READ, 0, 0, 0, 0, 0, 0, 0));
    wait_drained();

    for (int ph = 0; ph < 4; ph++) begin
      reg_write(phase_keep[ph]);
      idle_pct = phase_idle[ph];
      stream_pos = (ph == 2) ? 32'hffff_0000 : $urandom;
      for (int j = 0; j < 360; j++) pending_items.push_back(random_item());
      wait_drained();
    end
    reg_write(1'b1);
    reg_write(1'b0);

    repeat (200) @(posedge clk);
    $display("checked %0d results: %0d stored, %0d read, %0d seeks found,",
             checked, ok_writes, ok_reads, ok_seeks);
    $display("%0d full rejections, %0d stale rejections", full_hits, stale_hits);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    #40ms;
    $display("FAILED: results differ");
    $finish;
  end

endmodule
